// ===== hw/rtl/ptel_pkg.sv =====
// Shared widths, limits and controller-datapath interface types.
`default_nettype none
package ptel_pkg;

  localparam int unsigned MAX_ROW   = 34;
  localparam int unsigned ROW_W     = 6;
  localparam int unsigned COL_W     = 7;
  localparam int unsigned VALUE_W   = 31;
  localparam int unsigned FACTOR_W  = 6;
  localparam int unsigned PROD_W    = VALUE_W + FACTOR_W;
  localparam int unsigned DIVCNT_W  = $clog2(PROD_W + 1);

  typedef struct packed {
    logic load;
    logic mul;
    logic div_step;
    logic writeback;
  } cmd_t;

  typedef struct packed {
    logic iter_done;
    logic div_last;
  } stat_t;

endpackage
`default_nettype wire

// ===== hw/rtl/ptel_ctrl.sv =====
// Sequencer for the multiply then exact-divide loop.
`default_nettype none
module ptel_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  ptel_pkg::stat_t    stat,
  output ptel_pkg::cmd_t     cmd,
  output logic               busy,
  output logic               done
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_MUL,
    ST_DIV,
    ST_WB
  } state_t;

  state_t state;

  always_comb begin
    cmd           = '0;
    cmd.load      = (state == ST_IDLE) && start && !busy;
    cmd.mul       = (state == ST_MUL);
    cmd.div_step  = (state == ST_DIV);
    cmd.writeback = (state == ST_WB);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy  <= 1'b0;
      done  <= 1'b0;
    end else begin
      done <= (state == ST_CHECK) && stat.iter_done;
      case (state)
        ST_IDLE: begin
          if (start && !busy) begin
            state <= ST_CHECK;
            busy  <= 1'b1;
          end
        end
        ST_CHECK: begin
          if (stat.iter_done) begin
            state <= ST_IDLE;
            busy  <= 1'b0;
          end else begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (stat.div_last) begin
            state <= ST_WB;
          end
        end
        ST_WB: begin
          state <= ST_CHECK;
        end
        default: begin
          state <= ST_IDLE;
          busy  <= 1'b0;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ptel_dpath.sv =====
// Running product, multiplier and radix-2 restoring divider.
`default_nettype none
module ptel_dpath (
  input  wire logic                            clk,
  input  ptel_pkg::cmd_t                       cmd,
  input  wire logic [ptel_pkg::ROW_W-1:0]      row,
  input  wire logic [ptel_pkg::COL_W-1:0]      col,
  output ptel_pkg::stat_t                      stat,
  output logic      [ptel_pkg::VALUE_W-1:0]    value
);

  logic [ptel_pkg::VALUE_W-1:0]  prod;
  logic [ptel_pkg::FACTOR_W-1:0] n;
  logic [ptel_pkg::FACTOR_W-1:0] k;
  logic [ptel_pkg::FACTOR_W-1:0] i;
  logic [ptel_pkg::PROD_W-1:0]   quo;
  logic [ptel_pkg::FACTOR_W-1:0] rem;
  logic [ptel_pkg::DIVCNT_W-1:0] cnt;

  logic                          in_ok;
  logic [ptel_pkg::COL_W-1:0]    col_m1;
  logic [ptel_pkg::FACTOR_W-1:0] factor;
  logic [ptel_pkg::FACTOR_W-1:0] divisor;
  logic [ptel_pkg::PROD_W-1:0]   product;
  logic [ptel_pkg::FACTOR_W:0]   trial;
  logic                          fits;

  always_comb begin
    in_ok   = (row != '0) && (row <= ptel_pkg::ROW_W'(ptel_pkg::MAX_ROW)) &&
              (col != '0) && (col <= ptel_pkg::COL_W'(row));
    col_m1  = col - ptel_pkg::COL_W'(1);
    factor  = n - i;
    divisor = i + ptel_pkg::FACTOR_W'(1);
    product = ptel_pkg::PROD_W'(prod) * ptel_pkg::PROD_W'(factor);
    trial   = {rem, quo[ptel_pkg::PROD_W-1]};
    fits    = trial >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n    <= row - ptel_pkg::ROW_W'(1);
      k    <= in_ok ? col_m1[ptel_pkg::FACTOR_W-1:0] : '0;
      i    <= '0;
      prod <= in_ok ? ptel_pkg::VALUE_W'(1) : '0;
    end
    if (cmd.mul) begin
      quo <= product;
      rem <= '0;
      cnt <= ptel_pkg::DIVCNT_W'(ptel_pkg::PROD_W);
    end
    if (cmd.div_step) begin
      quo <= {quo[ptel_pkg::PROD_W-2:0], fits};
      rem <= fits ? ptel_pkg::FACTOR_W'(trial - {1'b0, divisor})
                  : trial[ptel_pkg::FACTOR_W-1:0];
      cnt <= cnt - ptel_pkg::DIVCNT_W'(1);
    end
    if (cmd.writeback) begin
      prod <= quo[ptel_pkg::VALUE_W-1:0];
      i    <= i + ptel_pkg::FACTOR_W'(1);
    end
  end

  always_comb begin
    stat.iter_done = (i == k);
    stat.div_last  = (cnt == ptel_pkg::DIVCNT_W'(1));
  end

  assign value = prod;

endmodule
`default_nettype wire

// ===== hw/rtl/pascal_triangle_element_unit.sv =====
// Top level: binomial coefficient C(row-1, col-1) of Pascal's triangle.
//
// Usage:
//   Drive row and col and raise start. The beat is taken at the rising edge
//   where start is high and busy is low; busy then stays high until the
//   result is out. A row outside 1..34, a column of zero or a column beyond
//   the row gives a value of zero.
//   The result shows on value with done high for exactly one cycle. The
//   receiver cannot stall: it must take value in that cycle. A new beat may
//   be started in the same cycle that done is high.
// Sequencing:
//   For valid inputs the loop runs col - 1 iterations, each a check, a
//   multiply, a bit-serial pass of the radix-2 divider and a writeback;
//   a final check then raises done. When the result is zero by range,
//   the first check raises done. Items are handled one at a time.
// Reset:
//   rst is synchronous and active high; it returns the sequencer to idle
//   and drops busy and done. Any item in flight is abandoned.
`default_nettype none
module pascal_triangle_element_unit (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [ptel_pkg::ROW_W-1:0]   row,
  input  wire logic [ptel_pkg::COL_W-1:0]   col,
  output logic                              busy,
  output logic                              done,
  output logic      [ptel_pkg::VALUE_W-1:0] value
);

  ptel_pkg::cmd_t  cmd;
  ptel_pkg::stat_t stat;

  ptel_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  ptel_dpath u_dpath (
    .clk   (clk),
    .cmd   (cmd),
    .row   (row),
    .col   (col),
    .stat  (stat),
    .value (value)
  );

endmodule
`default_nettype wire
